FILE: rtl/trm_pkg.sv
// Shared package of the tiny register machine execute block.
// Holds field widths, parameter defaults, opcode and state types and index helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trm_pkg;

  // Defaults for the top-level parameters.
  localparam int MEM_DEPTH_DEF = 1024;
  localparam int REG_COUNT_DEF = 4;
  localparam int PC_BITS_DEF   = 16;

  // Fixed widths of the word fields.
  localparam int DATA_W    = 32;
  localparam int IMM_W     = 16;
  localparam int OP_W      = 4;
  localparam int REG_SEL_W = 2;
  localparam int ADDR_IN_W = 10;
  localparam int TARGET_W  = 16;
  localparam int NPC_W     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_MOVR  = 4'd0,
    OP_MOVI  = 4'd1,
    OP_ADDR  = 4'd2,
    OP_ADDI  = 4'd3,
    OP_SUBR  = 4'd4,
    OP_SUBI  = 4'd5,
    OP_MULR  = 4'd6,
    OP_MULI  = 4'd7,
    OP_DIVR  = 4'd8,
    OP_DIVI  = 4'd9,
    OP_LOAD  = 4'd10,
    OP_STORE = 4'd11,
    OP_JMP   = 4'd12,
    OP_JMPZ  = 4'd13
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OPER,
    ST_DIV,
    ST_FIN
  } state_t;

  // Register selector reduced modulo the register count. The selector is below
  // twice any legal count, so one compare and subtract is enough.
  function automatic logic [3:0] reg_index(input logic [REG_SEL_W-1:0] sel, input int count);
    int v;
    v = int'(sel);
    if (v >= count) begin
      v = v - count;
    end
    return 4'(v);
  endfunction

  // Word address reduced modulo the memory depth by restoring subtraction of the
  // depth scaled by 32 down to 1; the quotient never exceeds six bits.
  function automatic logic [ADDR_IN_W-1:0] addr_index(input logic [ADDR_IN_W-1:0] a,
                                                      input int depth);
    int v;
    v = int'(a);
    for (int k = 5; k >= 0; k--) begin
      if (v >= (depth << k)) begin
        v = v - (depth << k);
      end
    end
    return ADDR_IN_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/trm_regfile.sv
// Register file of the tiny register machine: one write port, two registered read ports.
// Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trm_regfile
  import trm_pkg::*;
#(
  parameter int DEPTH = REG_COUNT_DEF,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [IW-1:0]     raddr_a,
  input  logic [IW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trm_dmem.sv
// Data memory of the tiny register machine: single port, registered read data.
// Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trm_dmem
  import trm_pkg::*;
#(
  parameter int DEPTH = MEM_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic [AW-1:0]     addr,
  input  logic              we,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trm_div
  import trm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CW = $clog2(DATA_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic              neg;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   rem;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_dif;

  // The remainder stays below the divisor magnitude, so the shifted value fits
  // and the top bit of the difference is a clean borrow.
  always_comb begin
    rem_sh  = {rem[DATA_W-1:0], quo[DATA_W-1]};
    rem_dif = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      quo <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (!rem_dif[DATA_W]) begin
        rem <= rem_dif;
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

`default_nettype wire

FILE: rtl/tiny_register_machine_execute_top.sv
// Tiny register machine execute stage: one decoded instruction word in, one result word out.
// Each accepted word passes through ST_OPER and ST_FIN, and through ST_DIV between them for
// a division with a nonzero divisor; ST_FIN loads the result register once the output
// register is free. A new word is taken only after that, and a division waits on the 32-step iterative divider.
// Reset: synchronous; afterwards a clearing pass zeroes the data memory and the register file
// while in_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module tiny_register_machine_execute_top
  import trm_pkg::*;
#(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF,
  parameter int PC_BITS   = PC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Instruction channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          op,
  input  logic [REG_SEL_W-1:0]     dest_reg,
  input  logic [REG_SEL_W-1:0]     src_reg,
  input  logic signed [DATA_W-1:0] immediate,
  input  logic [ADDR_IN_W-1:0]     mem_addr,
  input  logic [TARGET_W-1:0]      jump_target,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NPC_W-1:0]         next_pc,
  output logic signed [DATA_W-1:0] written_value,
  output logic signed [DATA_W-1:0] r0_value,
  output logic                     divide_error
);

  localparam int RW = $clog2(REG_COUNT);
  localparam int AW = $clog2(MEM_DEPTH);

  // The machine works on one word at a time. A word is accepted in ST_IDLE, and at that
  // same edge both register operands and the memory word are read. ST_OPER computes the
  // result (or starts the divider), and ST_FIN writes the register file or memory back and
  // loads the output register. Since the write-back edge always precedes the next
  // acceptance, a following word never reads stale state and no forwarding is needed.

  state_t state;
  state_t state_next;

  logic          in_acc;
  logic          out_free;
  logic          fin_go;
  logic          div_start;
  logic          div_done;
  logic [AW-1:0] clr_cnt;
  logic          clr_last;
  logic          clr_reg;

  logic [RW-1:0] in_rd;
  logic [RW-1:0] in_rs;
  logic [AW-1:0] in_addr;

  // Fields of the word in flight.
  op_t                op_q;
  logic [RW-1:0]      rd_q;
  logic [DATA_W-1:0]  imm_q;
  logic [AW-1:0]      addr_q;
  logic [PC_BITS-1:0] target_q;

  // Memory read data, valid from ST_OPER on.
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] rs_data;
  logic [DATA_W-1:0] mem_data;

  // Execute results.
  logic [DATA_W-1:0] opnd;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] ex_wv;
  logic              ex_wreg;
  logic              ex_wmem;
  logic              ex_derr;
  logic              ex_jump;
  logic              ex_div;

  logic [DATA_W-1:0] res_wv;
  logic              res_wreg;
  logic              res_wmem;
  logic              res_derr;
  logic              res_jump;

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  logic [DATA_W-1:0]  r0;
  logic               r0_hit;

  // Write ports.
  logic              rf_we;
  logic [RW-1:0]     rf_waddr;
  logic [DATA_W-1:0] rf_wdata;
  logic [AW-1:0]     dm_addr;
  logic              dm_we;
  logic [DATA_W-1:0] dm_wdata;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign clr_last = (clr_cnt == AW'(MEM_DEPTH - 1));
  // Only the first REG_COUNT steps of the clearing pass touch the register file.
  assign clr_reg  = (state == ST_CLEAR) && (int'(clr_cnt) < REG_COUNT);

  // Selectors wrap modulo the register count and the memory depth.
  assign in_rd   = RW'(reg_index(dest_reg, REG_COUNT));
  assign in_rs   = RW'(reg_index(src_reg, REG_COUNT));
  assign in_addr = AW'(addr_index(mem_addr, MEM_DEPTH));

  // Sequencer.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    fin_go     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_OPER;
        end
      end
      ST_OPER: begin
        if (ex_div) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // Write-back and the output load wait together for a free output register.
        if (out_free) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Execute. Odd codes among the arithmetic operations take the immediate, of which only
  // the low sixteen bits count, zero-extended.
  always_comb begin
    opnd    = op_q[0] ? {{(DATA_W - IMM_W){1'b0}}, imm_q[IMM_W-1:0]} : rs_data;
    prod    = rd_data * opnd;
    ex_wv   = '0;
    ex_wreg = 1'b0;
    ex_wmem = 1'b0;
    ex_derr = 1'b0;
    ex_jump = 1'b0;
    ex_div  = 1'b0;
    unique case (op_q) inside
      OP_MOVR: begin
        ex_wv   = rs_data;
        ex_wreg = 1'b1;
      end
      OP_MOVI: begin
        ex_wv   = imm_q;
        ex_wreg = 1'b1;
      end
      OP_ADDR, OP_ADDI: begin
        ex_wv   = rd_data + opnd;
        ex_wreg = 1'b1;
      end
      OP_SUBR, OP_SUBI: begin
        ex_wv   = rd_data - opnd;
        ex_wreg = 1'b1;
      end
      OP_MULR, OP_MULI: begin
        ex_wv   = prod;
        ex_wreg = 1'b1;
      end
      OP_DIVR, OP_DIVI: begin
        // A zero divisor leaves the destination alone and only raises the error flag.
        if (opnd == '0) begin
          ex_derr = 1'b1;
        end else begin
          ex_div = 1'b1;
        end
      end
      OP_LOAD: begin
        ex_wv   = mem_data;
        ex_wreg = 1'b1;
      end
      OP_STORE: begin
        ex_wv   = rd_data;
        ex_wmem = 1'b1;
      end
      OP_JMP: begin
        ex_jump = 1'b1;
      end
      OP_JMPZ: begin
        ex_jump = (r0 == '0);
      end
      default: begin
        // Undefined codes do nothing but advance the program counter.
      end
    endcase
  end

  assign pc_next = res_jump ? target_q : pc + 1'b1;
  assign r0_hit  = res_wreg && (rd_q == '0);

  // Write-port steering: the clearing pass owns both memories until it ends.
  always_comb begin
    rf_we    = clr_reg || (fin_go && res_wreg);
    rf_waddr = (state == ST_CLEAR) ? RW'(clr_cnt) : rd_q;
    rf_wdata = (state == ST_CLEAR) ? '0 : res_wv;
    dm_we    = (state == ST_CLEAR) || (fin_go && res_wmem);
    dm_wdata = (state == ST_CLEAR) ? '0 : res_wv;
    if (state == ST_CLEAR) begin
      dm_addr = clr_cnt;
    end else if (state == ST_FIN) begin
      dm_addr = addr_q;
    end else begin
      dm_addr = in_addr;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pc        <= '0;
      r0        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (fin_go) begin
        pc        <= pc_next;
        out_valid <= 1'b1;
        if (r0_hit) begin
          r0 <= res_wv;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q     <= op_t'(op);
      rd_q     <= in_rd;
      imm_q    <= $unsigned(immediate);
      addr_q   <= in_addr;
      target_q <= PC_BITS'(jump_target);
    end
    if (state == ST_OPER) begin
      res_wv   <= ex_wv;
      res_wreg <= ex_wreg;
      res_wmem <= ex_wmem;
      res_derr <= ex_derr;
      res_jump <= ex_jump;
    end else if (state == ST_DIV && div_done) begin
      res_wv   <= div_quo;
      res_wreg <= 1'b1;
    end
    if (fin_go) begin
      next_pc       <= NPC_W'(pc_next);
      written_value <= $signed(res_wv);
      r0_value      <= $signed(r0_hit ? res_wv : r0);
      divide_error  <= res_derr;
    end
  end

  trm_regfile #(
    .DEPTH(REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .re      (in_acc),
    .raddr_a (in_rd),
    .raddr_b (in_rs),
    .rdata_a (rd_data),
    .rdata_b (rs_data)
  );

  trm_dmem #(
    .DEPTH(MEM_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .addr  (dm_addr),
    .we    (dm_we),
    .wdata (dm_wdata),
    .re    (in_acc),
    .rdata (mem_data)
  );

  trm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (opnd),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

FILE: rtl/trm_checker.sv
// Port-level checks for the tiny register machine execute block, bound to its top level.
// Depends on trm_pkg and tiny_register_machine_execute_top.
`timescale 1ns / 1ps
`default_nettype none

module trm_checker
  import trm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [NPC_W-1:0]  next_pc,
  input wire logic [DATA_W-1:0] written_value,
  input wire logic [DATA_W-1:0] r0_value,
  input wire logic              divide_error
);

  // The machine holds one word at a time, so it is never ready right after accepting.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // The clearing pass follows reset, so no word can be taken straight after it.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("ready directly after reset");

  // A failed division writes nothing.
  a_div_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> written_value == '0)
    else $error("divide error with a nonzero written word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(written_value)
      && $stable(r0_value) && $stable(divide_error))
    else $error("stalled result word changed");

endmodule

bind tiny_register_machine_execute_top trm_checker u_trm_checker (.*);

`default_nettype wire
